/* sv/tmas_pkg.sv */
// Package for the trimmed mean ADC scaler: sizes, register indexes,
// reset values and the structs passed between the block's modules.
// Has no dependencies.
package tmas_pkg;

  localparam int BATCH_SIZE  = 10;
  localparam int SAMPLE_BITS = 12;

  localparam int IN_W      = 12;
  localparam int CNT_W     = $clog2(BATCH_SIZE + 1);
  localparam int SUM_W     = SAMPLE_BITS + CNT_W;
  localparam int MULT_W    = 20;
  localparam int DEN_W     = 20;
  localparam int OFF_W     = 8;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_W     = SAMPLE_BITS + MULT_W;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int SCALED_W  = 20;
  localparam int CODE_W    = 12;
  localparam int KEPT_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd2;

  localparam logic [MULT_W-1:0] MULT_RST = MULT_W'(19800);
  localparam logic [DEN_W-1:0]  DEN_RST  = DEN_W'(4095);
  localparam logic [OFF_W-1:0]  OFF_RST  = '0;

  localparam logic [SCALED_W-1:0] SCALED_TOP = '1;
  localparam logic [CODE_W-1:0]   CODE_TOP   = '1;

  typedef struct packed {
    logic [CNT_W-1:0]       pos;
    logic [SUM_W-1:0]       sum;
    logic [SAMPLE_BITS-1:0] lo;
    logic [CNT_W-1:0]       lo_hits;
    logic [SAMPLE_BITS-1:0] hi;
    logic [CNT_W-1:0]       hi_hits;
  } stats_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/tmas_stats.sv */
// Batch statistics for the trimmed mean ADC scaler: running sum, lowest and
// highest sample and their hit counts. Depends on tmas_pkg.
module tmas_stats (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      acc_i,
  input  logic [tmas_pkg::IN_W-1:0] sample_i,
  input  logic                      clear_i,
  output tmas_pkg::stats_t          stats_o
);

  tmas_pkg::stats_t                 st_q, st_d;
  logic [tmas_pkg::SAMPLE_BITS-1:0] smp;
  logic                             first;

  assign smp     = tmas_pkg::SAMPLE_BITS'(sample_i);
  assign first   = (st_q.pos == '0);
  assign stats_o = st_q;

  always_comb begin
    st_d = st_q;
    if (clear_i) begin
      st_d.pos     = '0;
      st_d.sum     = '0;
      st_d.lo      = '1;
      st_d.lo_hits = '0;
      st_d.hi      = '0;
      st_d.hi_hits = '0;
    end else if (acc_i) begin
      if (first || smp < st_q.lo) begin
        st_d.lo      = smp;
        st_d.lo_hits = tmas_pkg::CNT_W'(1);
      end else if (smp == st_q.lo) begin
        st_d.lo_hits = st_q.lo_hits + tmas_pkg::CNT_W'(1);
      end
      if (first || smp > st_q.hi) begin
        st_d.hi      = smp;
        st_d.hi_hits = tmas_pkg::CNT_W'(1);
      end else if (smp == st_q.hi) begin
        st_d.hi_hits = st_q.hi_hits + tmas_pkg::CNT_W'(1);
      end
      st_d.sum = st_q.sum + tmas_pkg::SUM_W'(smp);
      st_d.pos = st_q.pos + tmas_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.pos     <= '0;
      st_q.sum     <= '0;
      st_q.lo      <= '1;
      st_q.lo_hits <= '0;
      st_q.hi      <= '0;
      st_q.hi_hits <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

/* sv/tmas_div.sv */
// Shared restoring divider for the trimmed mean ADC scaler, one quotient
// bit per cycle. Depends on tmas_pkg.
module tmas_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmas_pkg::div_req_t req_i,
  output tmas_pkg::div_rsp_t rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [tmas_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [tmas_pkg::DIV_W-1:0]     quo_q, quo_d;
  logic [tmas_pkg::DEN_W-1:0]     rem_q, rem_d;
  logic [tmas_pkg::DEN_W-1:0]     den_q, den_d;
  logic [tmas_pkg::DEN_W:0]       shifted;
  logic [tmas_pkg::DEN_W:0]       diff;
  logic                           fits;

  assign shifted = {rem_q, quo_q[tmas_pkg::DIV_W-1]};
  assign fits    = (shifted >= {1'b0, den_q});
  assign diff    = shifted - {1'b0, den_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = tmas_pkg::DIV_CNT_W'(tmas_pkg::DIV_W - 1);
      quo_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      // A partial remainder that does not fit is below the divisor, so its
      // top bit is clear and it drops back to divisor width safely.
      rem_d = fits ? diff[tmas_pkg::DEN_W-1:0] : shifted[tmas_pkg::DEN_W-1:0];
      quo_d = {quo_q[tmas_pkg::DIV_W-2:0], fits};
      cnt_d = cnt_q - tmas_pkg::DIV_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

endmodule

/* sv/trimmed_mean_adc_scaler.sv */
// Top level of the trimmed mean ADC scaler: configuration registers, the
// end-of-batch sequencer and the output register.
// Depends on tmas_pkg, tmas_stats and tmas_div.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_stall_o    sample_i
//   out      output     out_valid_o / out_stall_i  scaled_value_o, mean_code_o,
//                                                  kept_count_o, no_survivor_o
//   cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
// A sample that does not end a batch is taken without stalling the input.
// The last sample of a batch starts two passes through the shared divider,
// and the input stays stalled after it until its result is loaded.
// The result waits in an output register; the next batch can be collected
// meanwhile, but a new result is held back, with the input still stalled,
// until the previous one is taken.
// Reset is asynchronous, active low, clears the batch, presets config regs.
module trimmed_mean_adc_scaler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tmas_pkg::IN_W-1:0]           sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tmas_pkg::SCALED_W-1:0]       scaled_value_o,
  output logic [tmas_pkg::CODE_W-1:0]         mean_code_o,
  output logic [tmas_pkg::KEPT_W-1:0]         kept_count_o,
  output logic                                no_survivor_o,
  input  logic                                cfg_we_i,
  input  logic [tmas_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tmas_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV2 = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]                       state_q, state_d;
  logic [tmas_pkg::MULT_W-1:0]      mult_q;
  logic [tmas_pkg::DEN_W-1:0]       den_q;
  logic [tmas_pkg::OFF_W-1:0]       off_q;
  logic [tmas_pkg::CNT_W-1:0]       kept_q, kept_d;
  logic                             flag_q, flag_d;
  logic [tmas_pkg::SAMPLE_BITS-1:0] mean_q, mean_d;
  logic                             out_valid_q, out_valid_d;
  logic [tmas_pkg::SCALED_W-1:0]    scaled_q;
  logic [tmas_pkg::CODE_W-1:0]      code_q;
  logic [tmas_pkg::KEPT_W-1:0]      kept_out_q;
  logic                             flag_out_q;

  tmas_pkg::stats_t   stats;
  tmas_pkg::div_req_t div_req;
  tmas_pkg::div_rsp_t div_rsp;

  logic                             in_acc;
  logic                             out_acc;
  logic                             last;
  logic                             stats_clear;
  logic                             load_out;
  logic [tmas_pkg::CNT_W-1:0]       kept_calc;
  logic [tmas_pkg::SUM_W-1:0]       rest;
  logic [tmas_pkg::DIV_W-1:0]       product;
  logic [tmas_pkg::SCALED_W-1:0]    scaled_sat;
  logic [tmas_pkg::SCALED_W-1:0]    scaled_fin;
  logic [tmas_pkg::CODE_W-1:0]      code_fin;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign last       = (stats.pos == tmas_pkg::CNT_W'(tmas_pkg::BATCH_SIZE - 1));

  tmas_stats u_stats (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .sample_i (sample_i),
    .clear_i  (stats_clear),
    .stats_o  (stats)
  );

  tmas_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // When lowest and highest coincide every sample is trimmed away.
  assign kept_calc = (stats.lo == stats.hi) ? '0 :
                     tmas_pkg::CNT_W'(tmas_pkg::BATCH_SIZE) - stats.lo_hits - stats.hi_hits;
  assign rest = stats.sum
              - tmas_pkg::SUM_W'(tmas_pkg::SUM_W'(stats.lo) * tmas_pkg::SUM_W'(stats.lo_hits))
              - tmas_pkg::SUM_W'(tmas_pkg::SUM_W'(stats.hi) * tmas_pkg::SUM_W'(stats.hi_hits));

  assign product = tmas_pkg::DIV_W'(div_rsp.quotient[tmas_pkg::SAMPLE_BITS-1:0])
                 * tmas_pkg::DIV_W'(mult_q);

  // A zero divisor yields an all-ones quotient, which saturates here as well.
  assign scaled_sat = (div_rsp.quotient > tmas_pkg::DIV_W'(tmas_pkg::SCALED_TOP)) ?
                      tmas_pkg::SCALED_TOP : div_rsp.quotient[tmas_pkg::SCALED_W-1:0];
  assign scaled_fin = (scaled_sat > tmas_pkg::SCALED_W'(off_q)) ?
                      scaled_sat - tmas_pkg::SCALED_W'(off_q) : '0;
  assign code_fin   = (tmas_pkg::DIV_W'(mean_q) > tmas_pkg::DIV_W'(tmas_pkg::CODE_TOP)) ?
                      tmas_pkg::CODE_TOP : tmas_pkg::CODE_W'(mean_q);

  assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    kept_d      = kept_q;
    flag_d      = flag_q;
    mean_d      = mean_q;
    stats_clear = 1'b0;
    div_req     = '0;
    out_valid_d = out_valid_q;
    if (out_acc) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        kept_d        = kept_calc;
        flag_d        = (kept_calc == '0);
        stats_clear   = 1'b1;
        div_req.start = 1'b1;
        if (kept_calc == '0) begin
          div_req.dividend = tmas_pkg::DIV_W'(stats.sum);
          div_req.divisor  = tmas_pkg::DEN_W'(tmas_pkg::BATCH_SIZE);
        end else begin
          div_req.dividend = tmas_pkg::DIV_W'(rest);
          div_req.divisor  = tmas_pkg::DEN_W'(kept_calc);
        end
        state_d = S_DIV1;
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        mean_d           = div_rsp.quotient[tmas_pkg::SAMPLE_BITS-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = product;
        div_req.divisor  = den_q;
        state_d          = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mult_q      <= tmas_pkg::MULT_RST;
      den_q       <= tmas_pkg::DEN_RST;
      off_q       <= tmas_pkg::OFF_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tmas_pkg::REG_MULT:   mult_q <= cfg_data_i[tmas_pkg::MULT_W-1:0];
          tmas_pkg::REG_DIV:    den_q  <= cfg_data_i[tmas_pkg::DEN_W-1:0];
          tmas_pkg::REG_OFFSET: off_q  <= cfg_data_i[tmas_pkg::OFF_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kept_q <= kept_d;
    flag_q <= flag_d;
    mean_q <= mean_d;
    if (load_out) begin
      scaled_q   <= scaled_fin;
      code_q     <= code_fin;
      kept_out_q <= tmas_pkg::KEPT_W'(kept_q);
      flag_out_q <= flag_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_value_o = scaled_q;
  assign mean_code_o    = code_q;
  assign kept_count_o   = kept_out_q;
  assign no_survivor_o  = flag_out_q;

endmodule

/* sv/tmas_chk.sv */
// Port-level checker for the trimmed mean ADC scaler, bound to the top level.
// Depends on tmas_pkg and trimmed_mean_adc_scaler.
module tmas_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [tmas_pkg::KEPT_W-1:0]         kept_count_o,
  input logic                                no_survivor_o
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The fallback flag goes with an empty trimmed set and only with it.
  a_flag_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (no_survivor_o == (kept_count_o == '0)))
    else $error("no_survivor does not match kept_count");

  // At least one lowest and one highest sample are always trimmed.
  a_kept_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kept_count_o <= tmas_pkg::KEPT_W'(tmas_pkg::BATCH_SIZE - 2)))
    else $error("kept_count too large");

  // A new result is only loaded while the input side is held off.
  a_load_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while input was open");

endmodule

bind trimmed_mean_adc_scaler tmas_chk u_tmas_chk (.*);

/* bench/tb.sv */
// Testbench for trimmed_mean_adc_scaler: random and directed sample batches,
// checked against a batch statistics predictor kept inside this file.
// Depends on tmas_pkg and the trimmed_mean_adc_scaler RTL.
module tb;
  import tmas_pkg::*;

  localparam int SAMPLE_MAX = (1 << IN_W) - 1;
  localparam int SETTLE_CYCLES = 2 * DIV_W + 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int BATCHES_PER_SETTING = 16;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {MIX_UNIFORM, MIX_CLUSTER, MIX_FLAT, MIX_TWO_LEVEL, MIX_RAILS} batch_mix_e;

  typedef struct packed {
    logic [SCALED_W-1:0] scaled_value;
    logic [CODE_W-1:0]   mean_code;
    logic [KEPT_W-1:0]   kept_count;
    logic                no_survivor;
  } batch_result_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [IN_W-1:0]      sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SCALED_W-1:0]  scaled_value_o;
  logic [CODE_W-1:0]    mean_code_o;
  logic [KEPT_W-1:0]    kept_count_o;
  logic                 no_survivor_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_MULT;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  logic [IN_W-1:0] sample_q[$];
  batch_result_t   result_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Mirror of the block's registers and batch statistics.
  logic [MULT_W-1:0] mult_reg;
  logic [DEN_W-1:0]  div_reg;
  logic [OFF_W-1:0]  off_reg;
  int batch_pos, acc_sum, low_code, low_hits, high_code, high_hits;

  trimmed_mean_adc_scaler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scaled_value_o (scaled_value_o),
    .mean_code_o    (mean_code_o),
    .kept_count_o   (kept_count_o),
    .no_survivor_o  (no_survivor_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic void start_batch();
    batch_pos = 0;
    acc_sum   = 0;
    low_code  = (1 << SAMPLE_BITS) - 1;
    low_hits  = 0;
    high_code = 0;
    high_hits = 0;
  endfunction

  // Folds one sample into the batch; returns 1 with the result when it closes the batch.
  function automatic bit fold_sample(input logic [IN_W-1:0] raw, output batch_result_t res);
    int     s;
    int     kept;
    int     mean;
    longint scaled;
    s = int'(raw) & ((1 << SAMPLE_BITS) - 1);
    if (batch_pos == 0 || s < low_code) begin
      low_code = s;
      low_hits = 1;
    end else if (s == low_code) begin
      low_hits++;
    end
    if (batch_pos == 0 || s > high_code) begin
      high_code = s;
      high_hits = 1;
    end else if (s == high_code) begin
      high_hits++;
    end
    acc_sum += s;
    batch_pos++;
    if (batch_pos < BATCH_SIZE) return 1'b0;

    kept = (low_code == high_code) ? 0 : BATCH_SIZE - low_hits - high_hits;
    if (kept == 0) begin
      mean = acc_sum / BATCH_SIZE;
    end else begin
      mean = (acc_sum - low_code * low_hits - high_code * high_hits) / kept;
    end

    if (div_reg == '0) begin
      scaled = longint'(SCALED_TOP);
    end else begin
      scaled = (longint'(mean) * longint'(mult_reg)) / longint'(div_reg);
      if (scaled > longint'(SCALED_TOP)) scaled = longint'(SCALED_TOP);
    end
    scaled = (scaled > longint'(off_reg)) ? scaled - longint'(off_reg) : 0;

    res.scaled_value = SCALED_W'(scaled);
    res.mean_code    = (mean > int'(CODE_TOP)) ? CODE_TOP : CODE_W'(mean);
    res.kept_count   = KEPT_W'(kept);
    res.no_survivor  = (kept == 0);
    start_batch();
    return 1'b1;
  endfunction

  // Sample driver: presents queued samples and folds each accepted one.
  always @(posedge clk_i) begin : drive_samples
    batch_result_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (fold_sample(sample_i, res)) result_q.push_back(res);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= sample_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted transaction with the oldest prediction.
  always @(posedge clk_i) begin : watch_results
    batch_result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result: scaled_value %0d mean_code %0d", scaled_value_o,
               mean_code_o);
        mismatches++;
      end else begin
        due = result_q.pop_front();
        if (scaled_value_o !== due.scaled_value) begin
          $error("scaled_value: expected %0d, got %0d", due.scaled_value, scaled_value_o);
          mismatches++;
        end
        if (mean_code_o !== due.mean_code) begin
          $error("mean_code: expected %0d, got %0d", due.mean_code, mean_code_o);
          mismatches++;
        end
        if (kept_count_o !== due.kept_count) begin
          $error("kept_count: expected %0d, got %0d", due.kept_count, kept_count_o);
          mismatches++;
        end
        if (no_survivor_o !== due.no_survivor) begin
          $error("no_survivor: expected %0d, got %0d", due.no_survivor, no_survivor_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MULT:   mult_reg = data[MULT_W-1:0];
      REG_DIV:    div_reg  = data[DEN_W-1:0];
      REG_OFFSET: off_reg  = data[OFF_W-1:0];
      default:    ;
    endcase
  endtask

  // Waits until every sample is taken and every result is out, then lets the
  // divider finish any batch that might still be closing.
  task automatic settle_idle();
    while (sample_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_batch(input batch_mix_e mix);
    int base_v, alt_v, v;
    base_v = $urandom_range(0, SAMPLE_MAX - 3);
    alt_v  = $urandom_range(0, SAMPLE_MAX);
    for (int i = 0; i < BATCH_SIZE; i++) begin
      case (mix)
        MIX_UNIFORM:   v = $urandom_range(0, SAMPLE_MAX);
        MIX_CLUSTER:   v = base_v + $urandom_range(0, 3);
        MIX_FLAT:      v = base_v;
        MIX_TWO_LEVEL: v = $urandom_range(0, 1) ? base_v : alt_v;
        default: begin
          v = $urandom_range(0, 2);
          if (v == 0) v = 0;
          else if (v == 1) v = SAMPLE_MAX;
          else v = $urandom_range(0, SAMPLE_MAX);
        end
      endcase
      sample_q.push_back(IN_W'(v));
    end
  endtask

  initial begin
    int rail_batch[10] = '{0, 4095, 0, 1, 2048, 4094, 2047, 4095, 1, 0};
    int bit_walk[5] = '{'hAAA, 'h555, 'hF0F, 'h0F0, 'h001};
    int mult_tab[9] = '{19800, 1048575, 0, 1048575, -1, 3300, 1048575, -1, 1};
    int div_tab[9]  = '{4095, 1, 1048575, 0, -1, 4095, 1048575, -1, 1};
    int off_tab[9]  = '{0, 255, 0, 17, -1, 255, 0, -1, 255};
    int send_tab[3] = '{16, 53, 0};
    int recv_tab[3] = '{53, 16, 0};
    int m, d, o;

    mult_reg = MULT_RST;
    div_reg  = DEN_RST;
    off_reg  = OFF_RST;
    start_batch();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = send_tab[0];
    recv_stall_pct = recv_tab[0];

    // A flat batch at full scale, then one crowded with both rails, then a
    // partial batch so that the next register writes land mid-batch.
    for (int i = 0; i < BATCH_SIZE; i++) sample_q.push_back(IN_W'(SAMPLE_MAX));
    foreach (rail_batch[i]) sample_q.push_back(IN_W'(rail_batch[i]));
    foreach (bit_walk[i]) sample_q.push_back(IN_W'(bit_walk[i]));
    settle_idle();
    program_reg(REG_UNUSED, CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));

    for (int s = 0; s < 9; s++) begin
      settle_idle();
      send_idle_pct  = send_tab[s / 3];
      recv_stall_pct = recv_tab[s / 3];
      m = (mult_tab[s] < 0) ? $urandom_range(0, (1 << MULT_W) - 1) : mult_tab[s];
      d = (div_tab[s] < 0) ? $urandom_range(1, (1 << DEN_W) - 1) : div_tab[s];
      o = (off_tab[s] < 0) ? $urandom_range(0, (1 << OFF_W) - 1) : off_tab[s];
      program_reg(REG_MULT, CFG_W'(m));
      program_reg(REG_DIV, CFG_W'(d));
      // Upper data bits are junk for the offset register and must be dropped.
      program_reg(REG_OFFSET, {CFG_W'($urandom_range(0, 4095)) << OFF_W} | CFG_W'(o));
      if (s == 4) program_reg(REG_UNUSED, CFG_W'($urandom_range(0, (1 << CFG_W) - 1)));
      for (int b = 0; b < BATCHES_PER_SETTING; b++) begin
        push_batch(batch_mix_e'($urandom_range(0, 4)));
      end
    end

    settle_idle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tmas_pkg.sv
sv/tmas_stats.sv
sv/tmas_div.sv
sv/trimmed_mean_adc_scaler.sv
sv/tmas_chk.sv
bench/tb.sv
